[sv/pod_pkg.sv]
package pod_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DNUM_W  = 23;
   localparam int COUNT_W = 22;

   localparam int MAX_YEAR_DEF = 9999;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int NUM_DATES = 4;

   // floor(y / 100) = (y * 5243) >> 19, exact for y below 2**14
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_PW    = 27;
   localparam int Q_W          = 8;
   localparam int REM_W        = 7;

   localparam int DAYS_PER_YEAR = 365;
   localparam int CENTURY       = 100;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      logic              ok;
      logic [DNUM_W-1:0] num;
   } dnum_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

[sv/pod_date_num.sv]
module pod_date_num #(
   parameter int MAX_YEAR = pod_pkg::MAX_YEAR_DEF
) (
   input  pod_pkg::date_type date,
   output pod_pkg::dnum_type dnum
);

   localparam logic [16:0] MaxYearLim = 17'(MAX_YEAR);

   logic [pod_pkg::YEAR_W-1:0]    p;
   logic [pod_pkg::DIV100_PW-1:0] yprod;
   logic [pod_pkg::DIV100_PW-1:0] pprod;
   logic [pod_pkg::Q_W-1:0]       yq;
   logic [pod_pkg::Q_W-1:0]       pq;
   logic [pod_pkg::REM_W-1:0]     yrem;
   logic                          leap;
   logic                          ok;
   logic [pod_pkg::DAY_W-1:0]     mlen;
   logic [pod_pkg::DNUM_W-1:0]    num;

   always_comb begin
      p     = date.year - pod_pkg::YEAR_W'(1);
      yprod = pod_pkg::DIV100_PW'(date.year) * pod_pkg::DIV100_PW'(pod_pkg::DIV100_MUL);
      pprod = pod_pkg::DIV100_PW'(p) * pod_pkg::DIV100_PW'(pod_pkg::DIV100_MUL);
      yq    = yprod[pod_pkg::DIV100_SHIFT +: pod_pkg::Q_W];
      pq    = pprod[pod_pkg::DIV100_SHIFT +: pod_pkg::Q_W];
      yrem  = pod_pkg::REM_W'(date.year
                 - pod_pkg::YEAR_W'(yq) * pod_pkg::YEAR_W'(pod_pkg::CENTURY));
      // Gregorian rule: by 4, not by 100 unless by 400
      leap  = ((date.year[1:0] == 2'b00) && (yrem != '0))
            || ((yrem == '0) && (yq[1:0] == 2'b00));
      mlen  = pod_pkg::month_len(date.month, leap);
      ok    = (date.year != '0)
            && ({3'b000, date.year} <= MaxYearLim)
            && (date.month >= pod_pkg::MONTH_JAN)
            && (date.month <= pod_pkg::MONTH_DEC)
            && (date.day != '0)
            && (date.day <= mlen);
      num   = pod_pkg::DNUM_W'(p) * pod_pkg::DNUM_W'(pod_pkg::DAYS_PER_YEAR)
            + pod_pkg::DNUM_W'(p[pod_pkg::YEAR_W-1:2])
            - pod_pkg::DNUM_W'(pq)
            + pod_pkg::DNUM_W'(pq[pod_pkg::Q_W-1:2])
            + pod_pkg::DNUM_W'(pod_pkg::days_before(date.month))
            + pod_pkg::DNUM_W'((date.month > pod_pkg::MONTH_FEB) && leap)
            + pod_pkg::DNUM_W'(date.day);
      dnum.ok  = ok;
      dnum.num = ok ? num : '0;
   end

endmodule

[sv/pod_overlap.sv]
module pod_overlap (
   input  pod_pkg::dnum_type                dn [pod_pkg::NUM_DATES],
   output logic [pod_pkg::COUNT_W-1:0]      count,
   output logic                             bad
);

   logic                        any_invalid;
   logic                        inverted;
   logic                        overlaps;
   logic [pod_pkg::DNUM_W-1:0]  lo;
   logic [pod_pkg::DNUM_W-1:0]  hi;
   logic [pod_pkg::DNUM_W-1:0]  diff;

   always_comb begin
      any_invalid = !dn[0].ok || !dn[1].ok || !dn[2].ok || !dn[3].ok;
      inverted    = (dn[1].num < dn[0].num) || (dn[3].num < dn[2].num);
      bad         = any_invalid || inverted;
      overlaps    = (dn[0].num <= dn[3].num) && (dn[2].num <= dn[1].num);
      lo          = (dn[0].num > dn[2].num) ? dn[0].num : dn[2].num;
      hi          = (dn[1].num < dn[3].num) ? dn[1].num : dn[3].num;
      diff        = hi - lo;
      if (bad || !overlaps) begin
         count = '0;
      end else if (diff > pod_pkg::DNUM_W'(pod_pkg::COUNT_MAX)) begin
         count = pod_pkg::COUNT_MAX;
      end else begin
         count = diff[pod_pkg::COUNT_W-1:0];
      end
   end

endmodule

[sv/period_overlap_days_core.sv]
// An accepted transaction passes the input, day-number and result stages in turn to rsp_*.
// Throughput: one transaction per cycle while rsp_stall is low; these three register stages
// each hold one transaction and advance whenever the next stage is free or being emptied.
// Reset: synchronous, active high; empties all three stages, payload registers are not reset.
module period_overlap_days_core #(
   parameter int MAX_YEAR = pod_pkg::MAX_YEAR_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pod_pkg::YEAR_W-1:0]    req_first_start_year,
   input  logic [pod_pkg::MONTH_W-1:0]   req_first_start_month,
   input  logic [pod_pkg::DAY_W-1:0]     req_first_start_day,
   input  logic [pod_pkg::YEAR_W-1:0]    req_first_end_year,
   input  logic [pod_pkg::MONTH_W-1:0]   req_first_end_month,
   input  logic [pod_pkg::DAY_W-1:0]     req_first_end_day,
   input  logic [pod_pkg::YEAR_W-1:0]    req_second_start_year,
   input  logic [pod_pkg::MONTH_W-1:0]   req_second_start_month,
   input  logic [pod_pkg::DAY_W-1:0]     req_second_start_day,
   input  logic [pod_pkg::YEAR_W-1:0]    req_second_end_year,
   input  logic [pod_pkg::MONTH_W-1:0]   req_second_end_month,
   input  logic [pod_pkg::DAY_W-1:0]     req_second_end_day,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pod_pkg::COUNT_W-1:0]   rsp_overlap_days,
   output logic                          rsp_bad_input
);

   pod_pkg::date_type               date_ff [pod_pkg::NUM_DATES];
   pod_pkg::date_type               date_in [pod_pkg::NUM_DATES];
   pod_pkg::dnum_type               dn_ff   [pod_pkg::NUM_DATES];
   pod_pkg::dnum_type               dn_in   [pod_pkg::NUM_DATES];
   logic [pod_pkg::COUNT_W-1:0]     count_ff;
   logic [pod_pkg::COUNT_W-1:0]     count_in;
   logic                            bad_ff;
   logic                            bad_in;
   logic                            v0_ff, v0_in;
   logic                            v1_ff, v1_in;
   logic                            v2_ff, v2_in;
   logic                            ready0, ready1, ready2;

   always_comb begin
      date_in[0] = '{year: req_first_start_year,  month: req_first_start_month,
                     day: req_first_start_day};
      date_in[1] = '{year: req_first_end_year,    month: req_first_end_month,
                     day: req_first_end_day};
      date_in[2] = '{year: req_second_start_year, month: req_second_start_month,
                     day: req_second_start_day};
      date_in[3] = '{year: req_second_end_year,   month: req_second_end_month,
                     day: req_second_end_day};
   end

   for (genvar g = 0; g < pod_pkg::NUM_DATES; g++) begin : g_date
      pod_date_num #(
         .MAX_YEAR (MAX_YEAR)
      ) u_date_num (
         .date (date_ff[g]),
         .dnum (dn_in[g])
      );
   end

   pod_overlap u_overlap (
      .dn    (dn_ff),
      .count (count_in),
      .bad   (bad_in)
   );

   always_comb begin
      ready2    = !v2_ff || !rsp_stall;
      ready1    = !v1_ff || ready2;
      ready0    = !v0_ff || ready1;
      req_stall = !ready0;
      v0_in     = ready0 ? req_valid : v0_ff;
      v1_in     = ready1 ? v0_ff : v1_ff;
      v2_in     = ready2 ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready0 && req_valid) begin
         date_ff <= date_in;
      end
      if (ready1 && v0_ff) begin
         dn_ff <= dn_in;
      end
      if (ready2 && v1_ff) begin
         count_ff <= count_in;
         bad_ff   <= bad_in;
      end
   end

   assign rsp_valid        = v2_ff;
   assign rsp_overlap_days = count_ff;
   assign rsp_bad_input    = bad_ff;

`ifndef SYNTHESIS
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_input) |-> (rsp_overlap_days == '0))
      else $error("bad transaction carries a non-zero count");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !v0_ff && !v1_ff))
      else $error("pipeline not empty after reset");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v0_ff)
      else $error("accepted transaction lost at input stage");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && rsp_stall) |=> (v1_ff && v2_ff))
      else $error("stalled stage dropped a transaction");
`endif

endmodule
